// ===== design/ttcg_pkg.sv =====
// Package for the two-tone chime generator: sizes, codes, phase steps,
// the quarter-wave sine table and the shared multiplier command type.
// No dependencies; every other design file refers to it by scoped name.
package ttcg_pkg;

  // core sizing
  localparam int PHASE_BITS     = 32;
  localparam int SINE_ADDR_BITS = 10;
  localparam int RAMP_LIMIT     = 480;

  localparam int SAMPLE_W = 16;
  localparam int MAG_W    = SAMPLE_W - 1;
  localparam int VOL_W    = 16;
  localparam int VOL_FRAC = 15;
  localparam logic [VOL_W-1:0] VOL_MAX   = VOL_W'(32768);
  localparam logic [VOL_W-1:0] VOL_RESET = VOL_W'(11469);

  // stream layout
  localparam int TYPE_W     = 2;
  localparam int EVENT_W    = 32;
  localparam int S_TDATA_W  = ((TYPE_W + EVENT_W + 7) / 8) * 8;
  localparam int S_TUSER_W  = 1;
  localparam int M_TDATA_W  = SAMPLE_W;
  localparam int M_TUSER_W  = 1;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;
  localparam logic [TYPE_W-1:0] TYPE_NONE = 2'd0;
  localparam logic [TYPE_W-1:0] TYPE_LEAD = 2'd1;

  // config port
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = VOL_W;
  localparam logic [CFG_ADDR_W-1:0] CFG_ENABLE = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_VOLUME = 1'd1;

  // chime timing
  localparam int LEN_TONE_A  = 5280;
  localparam int LEN_GAP     = 1920;
  localparam int LEN_B_LEAD  = 6720;
  localparam int LEN_B_OTHER = 7680;
  localparam int IDX_W       = $clog2(LEN_B_OTHER);

  localparam logic [1:0] SEG_TONE_A = 2'd0;
  localparam logic [1:0] SEG_GAP    = 2'd1;
  localparam logic [1:0] SEG_TONE_B = 2'd2;

  // tone A is the shortest tone, so its half length bounds every ramp
  localparam int RAMP_LEN = (RAMP_LIMIT < LEN_TONE_A / 2) ? RAMP_LIMIT : LEN_TONE_A / 2;
  localparam int NUM_W    = $clog2(RAMP_LEN + 1);

  // gain chain: |s| * vol -> * num -> >> 15 -> / RAMP_LEN (reciprocal)
  localparam int P1_W   = MAG_W + VOL_W;
  localparam int P2_W   = P1_W + NUM_W;
  localparam int Q_W    = P2_W - VOL_FRAC;
  localparam int RCP_SH = $clog2(RAMP_LEN);
  localparam int RCP_K  = Q_W + RCP_SH;
  localparam int RCP_W  = Q_W + 1;
  localparam logic [RCP_W-1:0] RCP_M =
    RCP_W'(((64'd1 << RCP_K) + 64'(RAMP_LEN) - 64'd1) / 64'(RAMP_LEN));

  localparam int MUL_A_W = P1_W;
  localparam int MUL_B_W = RCP_W;
  localparam int ACC_W   = MUL_A_W + MUL_B_W;

  // phase increments, round(f * 2^PHASE_BITS / 48 kHz), f in tenths of Hz
  localparam longint unsigned RATE_TENTHS = 64'd480000;
  localparam logic [PHASE_BITS-1:0] STEP_A_LEAD  =
    PHASE_BITS'(((64'd8800 << PHASE_BITS) + RATE_TENTHS / 2) / RATE_TENTHS);
  localparam logic [PHASE_BITS-1:0] STEP_A_OTHER =
    PHASE_BITS'(((64'd7840 << PHASE_BITS) + RATE_TENTHS / 2) / RATE_TENTHS);
  localparam logic [PHASE_BITS-1:0] STEP_B_LEAD  =
    PHASE_BITS'(((64'd11747 << PHASE_BITS) + RATE_TENTHS / 2) / RATE_TENTHS);
  localparam logic [PHASE_BITS-1:0] STEP_B_OTHER =
    PHASE_BITS'(((64'd10465 << PHASE_BITS) + RATE_TENTHS / 2) / RATE_TENTHS);

  // sine table
  localparam int QIDX_W  = SINE_ADDR_BITS - 2;
  localparam int QUARTER = 1 << QIDX_W;
  localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;

  typedef logic [MAG_W-1:0] qtab_t [QUARTER];

  // two Q30 multiplies by x
  function automatic longint unsigned taylor_pow2(input longint unsigned term,
                                                  input longint unsigned x);
    longint unsigned t;
    t = (term * x) >> 30;
    return (t * x) >> 30;
  endfunction

  // odd Taylor series through x^15 in Q30, scaled to Q0.15
  function automatic logic [MAG_W-1:0] quarter_sine(input int unsigned r);
    longint unsigned x, t1, t2, t3, t4, t5, t6, t7;
    longint sum, v;
    x  = (64'(r) * TWO_PI_Q30) >> SINE_ADDR_BITS;
    t1 = taylor_pow2(x, x) / 64'd6;
    t2 = taylor_pow2(t1, x) / 64'd20;
    t3 = taylor_pow2(t2, x) / 64'd42;
    t4 = taylor_pow2(t3, x) / 64'd72;
    t5 = taylor_pow2(t4, x) / 64'd110;
    t6 = taylor_pow2(t5, x) / 64'd156;
    t7 = taylor_pow2(t6, x) / 64'd210;
    sum = longint'(x) - longint'(t1) + longint'(t2) - longint'(t3)
        + longint'(t4) - longint'(t5) + longint'(t6) - longint'(t7);
    if (sum < 0) sum = 0;
    v = (sum * 64'sd32767 + 64'sd536870912) >>> 30;
    if (v > 64'sd32767) v = 64'sd32767;
    return MAG_W'(v);
  endfunction

  function automatic qtab_t build_qtab();
    qtab_t t;
    for (int i = 0; i < QUARTER; i++) begin
      t[i] = quarter_sine(i);
    end
    return t;
  endfunction

  localparam qtab_t QTAB = build_qtab();
  localparam logic [MAG_W-1:0] QS_PEAK = quarter_sine(QUARTER);

  // shared multiplier
  typedef enum logic [1:0] {
    MUL_VOL,
    MUL_NUM,
    MUL_RCP
  } mul_op_e;

  typedef struct packed {
    logic    en;
    mul_op_e op;
  } mul_cmd_t;

endpackage

// ===== design/two_tone_chime_generator.sv =====
// Two-tone chime generator. A start word is handled in idle alone; a tick
// word while idle or in the gap goes straight to the output load; a tone
// tick takes a table read, three passes through the one shared multiplier,
// then the output load. A new word is taken once the sequencer is back in
// idle; a stalled output holds the sequencer in its load step. Reset leaves
// the chime idle with enable = 1 and volume = 11469; there is no clearing pass.
module two_tone_chime_generator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // slave side
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [ttcg_pkg::S_TDATA_W-1:0]      s_axis_tdata,  // chime_type, alert_num
  input  logic [ttcg_pkg::S_TUSER_W-1:0]      s_axis_tuser,  // op
  // master side
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [ttcg_pkg::M_TDATA_W-1:0]      m_axis_tdata,  // sample
  output logic [ttcg_pkg::M_TUSER_W-1:0]      m_axis_tuser,  // playing
  output logic                                m_axis_tlast,
  // config
  input  logic                                cfg_we_i,
  input  logic [ttcg_pkg::CFG_ADDR_W-1:0]     cfg_addr_i,
  input  logic [ttcg_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_LOOK    = 3'd1;
  localparam logic [2:0] ST_MUL_VOL = 3'd2;
  localparam logic [2:0] ST_MUL_NUM = 3'd3;
  localparam logic [2:0] ST_MUL_RCP = 3'd4;
  localparam logic [2:0] ST_OUT     = 3'd5;

  localparam int PB = ttcg_pkg::PHASE_BITS;
  localparam int IW = ttcg_pkg::IDX_W;
  localparam int NW = ttcg_pkg::NUM_W;

  logic [2:0] state_q, state_d;

  // config
  logic                       enable_q;
  logic [ttcg_pkg::VOL_W-1:0] vol_q, vol_sat;

  // chime state
  logic          busy_q, busy_d;
  logic [1:0]    seg_q, seg_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [PB-1:0] phase_q, phase_d;
  logic          type_q, type_d;
  logic          pend_q, pend_d;
  logic          pend_kind_q, pend_kind_d;

  // per-tick latches
  logic [ttcg_pkg::SINE_ADDR_BITS-1:0] addr_q, addr_d;
  logic [NW-1:0]                       num_q, num_d;
  logic                                tone_q, tone_d;
  logic                                play_q, play_d;
  logic                                last_q, last_d;

  // output register
  logic                          m_valid_q, m_valid_d;
  logic                          m_load;
  logic [ttcg_pkg::SAMPLE_W-1:0] m_data_q, m_data_d;
  logic                          m_play_q;
  logic                          m_last_q;

  // decode of the input word
  logic                          in_op;
  logic [ttcg_pkg::TYPE_W-1:0]   in_type;
  logic [ttcg_pkg::EVENT_W-1:0]  in_event;
  logic                          in_fire;

  logic [IW-1:0] len_cur, idx_inc, rem;
  logic [PB-1:0] step_cur;
  logic          seg_end;
  logic [NW-1:0] num_c;

  logic [ttcg_pkg::MAG_W-1:0] rom_mag;
  logic                       rom_neg;
  logic [ttcg_pkg::ACC_W-1:0] acc;
  logic [ttcg_pkg::MAG_W-1:0] quot;
  ttcg_pkg::mul_cmd_t         mul_cmd;

  assign in_op    = s_axis_tuser[0];
  assign in_type  = s_axis_tdata[ttcg_pkg::TYPE_W-1:0];
  assign in_event = s_axis_tdata[ttcg_pkg::TYPE_W +: ttcg_pkg::EVENT_W];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign vol_sat = (vol_q > ttcg_pkg::VOL_MAX) ? ttcg_pkg::VOL_MAX : vol_q;

  // segment length and phase step of the running tone
  always_comb begin
    unique case (seg_q)
      ttcg_pkg::SEG_TONE_A: len_cur = IW'(ttcg_pkg::LEN_TONE_A);
      ttcg_pkg::SEG_GAP:    len_cur = IW'(ttcg_pkg::LEN_GAP);
      default:              len_cur = type_q ? IW'(ttcg_pkg::LEN_B_OTHER)
                                             : IW'(ttcg_pkg::LEN_B_LEAD);
    endcase
    if (seg_q == ttcg_pkg::SEG_TONE_A) begin
      step_cur = type_q ? ttcg_pkg::STEP_A_OTHER : ttcg_pkg::STEP_A_LEAD;
    end else begin
      step_cur = type_q ? ttcg_pkg::STEP_B_OTHER : ttcg_pkg::STEP_B_LEAD;
    end
  end

  assign idx_inc = idx_q + IW'(1);
  assign seg_end = (idx_inc == len_cur);
  assign rem     = len_cur - idx_q;

  // envelope numerator: rising ramp, flat top, falling ramp
  always_comb begin
    if (idx_q < IW'(ttcg_pkg::RAMP_LEN)) begin
      num_c = NW'(idx_q);
    end else begin
      num_c = NW'(ttcg_pkg::RAMP_LEN);
    end
    if (rem <= IW'(ttcg_pkg::RAMP_LEN) && rem < IW'(num_c)) begin
      num_c = NW'(rem);
    end
  end

  assign quot = acc[ttcg_pkg::RCP_K +: ttcg_pkg::MAG_W];

  always_comb begin
    state_d     = state_q;
    busy_d      = busy_q;
    seg_d       = seg_q;
    idx_d       = idx_q;
    phase_d     = phase_q;
    type_d      = type_q;
    pend_d      = pend_q;
    pend_kind_d = pend_kind_q;
    addr_d      = addr_q;
    num_d       = num_q;
    tone_d      = tone_q;
    play_d      = play_q;
    last_d      = last_q;
    m_valid_d   = m_valid_q && !m_axis_tready;
    m_load      = 1'b0;
    m_data_d    = '0;
    mul_cmd.en  = 1'b0;
    mul_cmd.op  = ttcg_pkg::MUL_VOL;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_op == ttcg_pkg::OP_START) begin
            if (enable_q && in_type != ttcg_pkg::TYPE_NONE && in_event != '0) begin
              if (busy_q) begin
                pend_d      = 1'b1;
                pend_kind_d = (in_type != ttcg_pkg::TYPE_LEAD);
              end else begin
                busy_d  = 1'b1;
                seg_d   = ttcg_pkg::SEG_TONE_A;
                idx_d   = '0;
                phase_d = '0;
                type_d  = (in_type != ttcg_pkg::TYPE_LEAD);
              end
            end
          end else begin
            play_d = busy_q;
            tone_d = busy_q && seg_q != ttcg_pkg::SEG_GAP;
            last_d = busy_q && seg_q == ttcg_pkg::SEG_TONE_B && seg_end;
            addr_d = phase_q[PB-1 -: ttcg_pkg::SINE_ADDR_BITS];
            num_d  = num_c;
            state_d = (busy_q && seg_q != ttcg_pkg::SEG_GAP) ? ST_LOOK : ST_OUT;
            if (busy_q) begin
              if (seg_q != ttcg_pkg::SEG_GAP) begin
                phase_d = phase_q + step_cur;
              end
              idx_d = idx_inc;
              if (seg_end) begin
                idx_d   = '0;
                phase_d = '0;
                seg_d   = seg_q + 2'd1;
                if (seg_q == ttcg_pkg::SEG_TONE_B) begin
                  // chime done; a queued request starts right away
                  seg_d  = ttcg_pkg::SEG_TONE_A;
                  busy_d = pend_q;
                  if (pend_q) begin
                    pend_d = 1'b0;
                    type_d = pend_kind_q;
                  end
                end
              end
            end
          end
        end
      end
      ST_LOOK: begin
        state_d = ST_MUL_VOL;
      end
      ST_MUL_VOL: begin
        mul_cmd.en = 1'b1;
        mul_cmd.op = ttcg_pkg::MUL_VOL;
        state_d    = ST_MUL_NUM;
      end
      ST_MUL_NUM: begin
        mul_cmd.en = 1'b1;
        mul_cmd.op = ttcg_pkg::MUL_NUM;
        state_d    = ST_MUL_RCP;
      end
      ST_MUL_RCP: begin
        mul_cmd.en = 1'b1;
        mul_cmd.op = ttcg_pkg::MUL_RCP;
        state_d    = ST_OUT;
      end
      ST_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_load    = 1'b1;
          m_valid_d = 1'b1;
          if (tone_q) begin
            m_data_d = rom_neg ? -{1'b0, quot} : {1'b0, quot};
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  ttcg_sine_rom u_sine_rom (
    .clk_i  (clk_i),
    .en_i   (state_q == ST_LOOK),
    .addr_i (addr_q),
    .mag_o  (rom_mag),
    .neg_o  (rom_neg)
  );

  ttcg_mul_unit u_mul_unit (
    .clk_i (clk_i),
    .cmd_i (mul_cmd),
    .mag_i (rom_mag),
    .vol_i (vol_sat),
    .num_i (num_q),
    .acc_o (acc)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      enable_q    <= 1'b1;
      vol_q       <= ttcg_pkg::VOL_RESET;
      busy_q      <= 1'b0;
      seg_q       <= ttcg_pkg::SEG_TONE_A;
      idx_q       <= '0;
      phase_q     <= '0;
      type_q      <= 1'b0;
      pend_q      <= 1'b0;
      pend_kind_q <= 1'b0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      busy_q      <= busy_d;
      seg_q       <= seg_d;
      idx_q       <= idx_d;
      phase_q     <= phase_d;
      type_q      <= type_d;
      pend_q      <= pend_d;
      pend_kind_q <= pend_kind_d;
      m_valid_q   <= m_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          ttcg_pkg::CFG_ENABLE: enable_q <= cfg_wdata_i[0];
          ttcg_pkg::CFG_VOLUME: vol_q    <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    num_q  <= num_d;
    tone_q <= tone_d;
    play_q <= play_d;
    last_q <= last_d;
    if (m_load) begin
      m_data_q <= m_data_d;
      m_play_q <= play_q;
      m_last_q <= last_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_play_q;
  assign m_axis_tlast  = m_last_q;

endmodule

// ===== design/ttcg_sine_rom.sv =====
// Sine lookup: folds the phase address into the quarter-wave table and
// registers magnitude and sign. Depends on ttcg_pkg.
module ttcg_sine_rom (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic [ttcg_pkg::SINE_ADDR_BITS-1:0] addr_i,
  output logic [ttcg_pkg::MAG_W-1:0]          mag_o,
  output logic                                neg_o
);

  logic [1:0]                    quad;
  logic [ttcg_pkg::QIDX_W:0]     r_fold;
  logic [ttcg_pkg::MAG_W-1:0]    mag_d, mag_q;
  logic                          neg_q;

  assign quad = addr_i[ttcg_pkg::SINE_ADDR_BITS-1 -: 2];

  always_comb begin
    r_fold = {1'b0, addr_i[ttcg_pkg::QIDX_W-1:0]};
    // falling quadrants run the table backwards
    if (quad[0]) begin
      r_fold = (ttcg_pkg::QIDX_W + 1)'(ttcg_pkg::QUARTER) - r_fold;
    end
    if (r_fold[ttcg_pkg::QIDX_W]) begin
      mag_d = ttcg_pkg::QS_PEAK;
    end else begin
      mag_d = ttcg_pkg::QTAB[r_fold[ttcg_pkg::QIDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q <= mag_d;
      neg_q <= quad[1];
    end
  end

  assign mag_o = mag_q;
  assign neg_o = neg_q;

endmodule

// ===== design/ttcg_mul_unit.sv =====
// Shared multiplier with its product register; the sequencer runs it three
// times per tone sample (volume, ramp, reciprocal). Depends on ttcg_pkg.
module ttcg_mul_unit (
  input  logic                         clk_i,
  input  ttcg_pkg::mul_cmd_t           cmd_i,
  input  logic [ttcg_pkg::MAG_W-1:0]   mag_i,
  input  logic [ttcg_pkg::VOL_W-1:0]   vol_i,
  input  logic [ttcg_pkg::NUM_W-1:0]   num_i,
  output logic [ttcg_pkg::ACC_W-1:0]   acc_o
);

  logic [ttcg_pkg::MUL_A_W-1:0] op_a;
  logic [ttcg_pkg::MUL_B_W-1:0] op_b;
  logic [ttcg_pkg::ACC_W-1:0]   acc_d, acc_q;

  always_comb begin
    unique case (cmd_i.op)
      ttcg_pkg::MUL_VOL: begin
        op_a = ttcg_pkg::MUL_A_W'(mag_i);
        op_b = ttcg_pkg::MUL_B_W'(vol_i);
      end
      ttcg_pkg::MUL_NUM: begin
        op_a = acc_q[ttcg_pkg::P1_W-1:0];
        op_b = ttcg_pkg::MUL_B_W'(num_i);
      end
      ttcg_pkg::MUL_RCP: begin
        // drop the fraction of the Q1.15 volume, then divide by the ramp length
        op_a = ttcg_pkg::MUL_A_W'(acc_q[ttcg_pkg::P2_W-1:ttcg_pkg::VOL_FRAC]);
        op_b = ttcg_pkg::RCP_M;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
    acc_d = ttcg_pkg::ACC_W'(op_a) * ttcg_pkg::ACC_W'(op_b);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.en) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

// ===== dv/testbench.sv =====
// Self-checking bench for the two-tone chime generator: a stream driver and
// monitor around the block, checked against a cycle-free chime predictor.
// Depends on design/ttcg_pkg.sv and design/two_tone_chime_generator.sv.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASE_W          = 32;
  localparam int WAVE_BITS        = 10;
  localparam int WAVE_LEN         = 1 << WAVE_BITS;
  localparam int QUARTER_LEN      = WAVE_LEN / 4;
  localparam int RAMP_MAX         = 480;
  localparam int TONE_A_LEN       = 5280;
  localparam int GAP_LEN          = 1920;
  localparam int TONE_B_LEAD_LEN  = 6720;
  localparam int TONE_B_OTHER_LEN = 7680;
  localparam int unsigned VOL_CEIL = 32768;
  localparam int unsigned VOL_DEFAULT = 11469;
  localparam longint unsigned TAU_Q30 = 64'd6746518852;
  localparam longint unsigned RATE_DECI_HZ = 64'd480000;
  localparam logic [1:0] TYPE_OTHER = 2'd2;
  localparam logic [1:0] TYPE_ALT   = 2'd3;  // decoded like the other chime
  localparam int DRAIN_CYCLES = 20;
  localparam int HANG_LIMIT   = 3000;
  localparam int MAX_REPORTS  = 10;

  typedef struct {
    logic        op;
    logic [1:0]  kind;
    logic [31:0] id;
  } chime_word_t;

  typedef struct packed {
    logic [15:0] sample;
    logic        playing;
    logic        last;
  } chime_out_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [ttcg_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;  // chime_type, alert_num
  logic [ttcg_pkg::S_TUSER_W-1:0] s_axis_tuser = '0;  // op
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [ttcg_pkg::M_TDATA_W-1:0] m_axis_tdata;       // sample
  logic [ttcg_pkg::M_TUSER_W-1:0] m_axis_tuser;       // playing
  logic m_axis_tlast;
  logic cfg_we_i = 1'b0;
  logic [ttcg_pkg::CFG_ADDR_W-1:0] cfg_addr_i = '0;
  logic [ttcg_pkg::CFG_DATA_W-1:0] cfg_wdata_i = '0;

  two_tone_chime_generator uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  wire s_fire = s_axis_tvalid && s_axis_tready;
  wire m_fire = m_axis_tvalid && m_axis_tready;

  // ---------------------------------------------------------------- predictor
  int          wave [WAVE_LEN];
  bit          en_reg = 1'b1;
  logic [15:0] vol_reg = 16'(VOL_DEFAULT);
  bit          chime_on;
  logic [1:0]  seg;
  int unsigned idx;
  logic [PHASE_W-1:0] phase;
  bit          other;          // active chime is the other (784 Hz) kind
  bit          queued;
  bit          queued_other;
  chime_out_t  exp_samples [$];
  int          fail_count;

  // round(32767 * sin(2*pi*r / WAVE_LEN)), odd series through x^15 in Q30
  function automatic int quarter_mag(input int unsigned r);
    longint unsigned x, term;
    longint acc, v;
    x = (64'(r) * TAU_Q30) >> WAVE_BITS;
    acc = longint'(x);
    term = x;
    for (int n = 1; n <= 7; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / 64'(2 * n * (2 * n + 1));
      if (n % 2) acc = acc - longint'(term);
      else acc = acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    v = (acc * 64'sd32767 + (64'sd1 <<< 29)) / (64'sd1 <<< 30);
    if (v > 64'sd32767) v = 64'sd32767;
    return int'(v);
  endfunction

  task automatic build_wave();
    int unsigned quad, r;
    int mag;
    for (int k = 0; k < WAVE_LEN; k++) begin
      quad = k / QUARTER_LEN;
      r = k % QUARTER_LEN;
      if (quad % 2) r = QUARTER_LEN - r;
      mag = quarter_mag(r);
      wave[k] = (quad >= 2) ? -mag : mag;
    end
  endtask

  function automatic int unsigned seg_length(input logic [1:0] s, input bit oth);
    if (s == ttcg_pkg::SEG_TONE_A) return TONE_A_LEN;
    if (s == ttcg_pkg::SEG_GAP) return GAP_LEN;
    return oth ? TONE_B_OTHER_LEN : TONE_B_LEAD_LEN;
  endfunction

  function automatic logic [PHASE_W-1:0] phase_inc(input logic [1:0] s, input bit oth);
    longint unsigned f10;
    if (s == ttcg_pkg::SEG_TONE_A) f10 = oth ? 64'd7840 : 64'd8800;
    else f10 = oth ? 64'd10465 : 64'd11747;
    return PHASE_W'(((f10 << PHASE_W) + RATE_DECI_HZ / 2) / RATE_DECI_HZ);
  endfunction

  function automatic logic [15:0] shaped_sample(input int unsigned len);
    int unsigned ramp, num, rem, gain, w_abs;
    int w;
    longint unsigned mag;
    ramp = len / 2;
    if (ramp > RAMP_MAX) ramp = RAMP_MAX;
    if (ramp == 0) ramp = 1;
    num = (idx < ramp) ? idx : ramp;
    rem = len - idx;
    if (rem <= ramp && rem < num) num = rem;
    gain = (vol_reg > VOL_CEIL) ? VOL_CEIL : vol_reg;
    w = wave[phase[PHASE_W-1 -: WAVE_BITS]];
    w_abs = (w < 0) ? -w : w;
    mag = 64'(w_abs) * 64'(gain) * 64'(num) / (64'(ramp) * 64'd32768);
    return (w < 0) ? -16'(mag) : 16'(mag);
  endfunction

  task automatic start_chime(input bit oth);
    chime_on = 1'b1;
    seg = ttcg_pkg::SEG_TONE_A;
    idx = 0;
    phase = '0;
    other = oth;
  endtask

  task automatic advance_chime(input logic op, input logic [1:0] kind,
                               input logic [31:0] id);
    chime_out_t res;
    int unsigned len;
    if (op == ttcg_pkg::OP_START) begin
      if (en_reg && kind != ttcg_pkg::TYPE_NONE && id != '0) begin
        if (chime_on) begin
          queued = 1'b1;
          queued_other = (kind != ttcg_pkg::TYPE_LEAD);
        end else begin
          start_chime(kind != ttcg_pkg::TYPE_LEAD);
        end
      end
      return;
    end
    res = '0;
    if (chime_on) begin
      len = seg_length(seg, other);
      res.sample  = (seg == ttcg_pkg::SEG_GAP) ? 16'd0 : shaped_sample(len);
      res.playing = 1'b1;
      res.last    = (seg == ttcg_pkg::SEG_TONE_B && idx == len - 1);
      if (seg != ttcg_pkg::SEG_GAP) phase = phase + phase_inc(seg, other);
      idx++;
      if (idx >= len) begin
        idx = 0;
        phase = '0;
        if (seg == ttcg_pkg::SEG_TONE_B) begin
          chime_on = 1'b0;
          seg = ttcg_pkg::SEG_TONE_A;
          // a queued request starts right behind the last sample
          if (queued) begin
            queued = 1'b0;
            start_chime(queued_other);
          end
        end else begin
          seg = seg + 2'd1;
        end
      end
    end
    exp_samples.push_back(res);
  endtask

  task automatic check_sample();
    chime_out_t want, got;
    got.sample  = m_axis_tdata;
    got.playing = m_axis_tuser[0];
    got.last    = m_axis_tlast;
    if (exp_samples.size() == 0) begin
      if (fail_count < MAX_REPORTS)
        $display("unexpected word: sample %0d playing %0b last %0b",
                 $signed(got.sample), got.playing, got.last);
      fail_count++;
      return;
    end
    want = exp_samples.pop_front();
    if (got.sample !== want.sample || got.playing !== want.playing ||
        got.last !== want.last) begin
      if (fail_count < MAX_REPORTS)
        $display("mismatch at %0t: sample %0d/%0d playing %0b/%0b last %0b/%0b (exp/got)",
                 $realtime, $signed(want.sample), $signed(got.sample),
                 want.playing, got.playing, want.last, got.last);
      fail_count++;
    end
  endtask

  // --------------------------------------------------------- monitor, checker
  bit word_taken;

  always @(posedge clk_i) begin
    word_taken <= s_fire;
    if (rst_ni) begin
      if (cfg_we_i) begin
        if (cfg_addr_i == ttcg_pkg::CFG_ENABLE) en_reg = cfg_wdata_i[0];
        else if (cfg_addr_i == ttcg_pkg::CFG_VOLUME) vol_reg = cfg_wdata_i;
      end
      if (s_fire)
        advance_chime(s_axis_tuser[0], s_axis_tdata[ttcg_pkg::TYPE_W-1:0],
                      s_axis_tdata[ttcg_pkg::TYPE_W +: ttcg_pkg::EVENT_W]);
      if (m_fire) check_sample();
    end
  end

  // ends the run when neither side moves a word for too long
  int idle_cycles;

  always @(posedge clk_i) begin
    if (!rst_ni || s_fire || m_fire) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == HANG_LIMIT) begin
      $display("two_tone_chime_generator test failed");
      $finish;
    end
  end

  // ------------------------------------------------------- driver, receiver
  chime_word_t tx_q [$];
  chime_word_t nxt_word;
  bit calm;
  int send_gap;
  int stall_left;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || word_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (tx_q.size() > 0) begin
        nxt_word = tx_q.pop_front();
        s_axis_tdata  <= ttcg_pkg::S_TDATA_W'({nxt_word.id, nxt_word.kind});
        s_axis_tuser  <= nxt_word.op;
        s_axis_tvalid <= 1'b1;
        send_gap = gap_len();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      stall_left = gap_len();
    end
  end

  // --------------------------------------------------------------- stimulus
  task automatic push_tick(input int n);
    chime_word_t w;
    repeat (n) begin
      w.op = ttcg_pkg::OP_TICK;
      w.kind = 2'($urandom_range(0, 3));  // don't-care on a tick
      w.id = $urandom();
      tx_q.push_back(w);
    end
  endtask

  task automatic push_req(input logic [1:0] kind, input logic [31:0] id);
    chime_word_t w;
    w.op = ttcg_pkg::OP_START;
    w.kind = kind;
    w.id = id;
    tx_q.push_back(w);
  endtask

  task automatic drain();
    while (tx_q.size() != 0 || s_axis_tvalid || exp_samples.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [ttcg_pkg::CFG_ADDR_W-1:0] addr,
                           input logic [ttcg_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= addr;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_burst(input int target);
    int cnt, r, n;
    logic [31:0] id;
    cnt = 0;
    while (cnt < target) begin
      r = $urandom_range(0, 99);
      id = $urandom();
      if (id == '0) id = 32'd1;
      if (r < 10) begin
        // well-formed: a request followed by a run of ticks
        push_req(2'($urandom_range(1, 3)), id);
        n = $urandom_range(5, 60);
        push_tick(n);
        cnt += n + 1;
      end else if (r < 16) begin
        if ($urandom_range(0, 1)) push_req(ttcg_pkg::TYPE_NONE, id);
        else push_req(2'($urandom_range(0, 3)), 32'd0);
        cnt++;
      end else if (r < 26) begin
        push_req(2'($urandom_range(1, 3)), id);
        cnt++;
      end else begin
        push_tick(1);
        cnt++;
      end
    end
    drain();
  endtask

  initial begin
    build_wave();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset values in force: enable on, default volume
    push_tick(1);
    push_req(ttcg_pkg::TYPE_NONE, 32'h0000_1234);
    push_tick(1);
    push_req(ttcg_pkg::TYPE_LEAD, 32'd0);
    push_tick(1);
    push_req(TYPE_OTHER, 32'hFFFF_FFFF);
    push_tick(3);
    push_req(ttcg_pkg::TYPE_LEAD, 32'd1);
    push_req(TYPE_ALT, 32'hAAAA_AAAA);
    push_req(ttcg_pkg::TYPE_LEAD, 32'h5555_5555);
    push_tick(25);
    drain();

    // full gain across the top of the rising ramp
    write_reg(ttcg_pkg::CFG_VOLUME, 16'd32768);
    write_reg(ttcg_pkg::CFG_ENABLE, 16'd1);
    calm = 1'b1;
    push_tick(480);
    push_req(TYPE_OTHER, 32'h0F0F_00F1);
    push_tick(20);
    drain();

    // disabled with gain above full scale: the running chime still plays
    write_reg(ttcg_pkg::CFG_ENABLE, 16'd0);
    write_reg(ttcg_pkg::CFG_VOLUME, 16'hFFFF);
    calm = 1'b0;
    push_req(ttcg_pkg::TYPE_LEAD, 32'h8000_0000);
    push_tick(20);
    push_req(TYPE_ALT, 32'h7FFF_FFFF);
    push_tick(20);
    drain();

    write_reg(ttcg_pkg::CFG_VOLUME, 16'd1);
    random_burst(65);

    write_reg(ttcg_pkg::CFG_ENABLE, 16'd1);
    write_reg(ttcg_pkg::CFG_VOLUME, 16'd0);
    random_burst(65);

    write_reg(ttcg_pkg::CFG_VOLUME, 16'($urandom_range(0, 65535)));
    calm = 1'b1;
    random_burst(65);

    write_reg(ttcg_pkg::CFG_VOLUME, 16'd32767);
    calm = 1'b0;
    random_burst(65);

    if (fail_count == 0) $display("two_tone_chime_generator test passed");
    else $display("two_tone_chime_generator test failed");
    $finish;
  end

endmodule
